// File: rtl/pnm_pkg.sv
// shared types, constants and phase encoding for the pnm stream decoder
package pnm_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIV_STEPS   = 24;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_MAGIC  = 2'd1;
    localparam logic [1:0] ERR_DIM    = 2'd2;
    localparam logic [1:0] ERR_MAXVAL = 2'd3;

    localparam logic [1:0] FMT_P2 = 2'd0;
    localparam logic [1:0] FMT_P3 = 2'd1;
    localparam logic [1:0] FMT_P5 = 2'd2;
    localparam logic [1:0] FMT_P6 = 2'd3;

    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_2  = 8'h32;
    localparam logic [7:0] CH_3  = 8'h33;
    localparam logic [7:0] CH_5  = 8'h35;
    localparam logic [7:0] CH_6  = 8'h36;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_FORMAT, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
        PH_PIXELS, PH_DONE, PH_ERROR
    } phase_t;

    // sequencer states
    typedef enum logic [1:0] {C_IDLE, C_DIV, C_SEND} ctrl_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
        logic        is_gray;
        logic [11:0] width_out;
        logic [11:0] height_out;
        logic [15:0] maxval_out;
        logic [1:0]  error_code;
    } out_beat_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;       // take the accepted byte
        logic       div_start;
        logic       div_step;
        logic       send;       // result register loaded
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       busy_result; // result register stays full this cycle
        logic       div_done;
        logic       need_div;    // byte closed an ascii sample
    } status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

// File: rtl/pnm_datapath.sv
// parser registers, sample divider, pixel counters and result register
module pnm_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pnm_pkg::in_beat_t    in_beat,
    input  pnm_pkg::cmd_t        cmd,
    output pnm_pkg::status_t     stat,
    output pnm_pkg::out_beat_t   m_beat,
    output logic                 m_valid,
    input  logic                 m_ready
);
    pnm_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [11:0] width_reg, width_next, height_reg, height_next;
    logic [15:0] maxs_reg, maxs_next, acc_reg, acc_next;
    logic        tok_reg, tok_next, com_reg, com_next, dd_reg, dd_next;
    logic [1:0]  chan_reg, chan_next;
    logic [7:0]  hred_reg, hred_next, hgrn_reg, hgrn_next;
    logic [11:0] col_reg, col_next, rowc_reg, rowc_next;
    pnm_pkg::out_beat_t res_reg, res_next;
    logic        valid_reg, valid_next;
    // restoring divider: numerator acc*255 (24 bits) by maxval
    logic [23:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic        gray;
    logic [7:0]  c;
    logic        closed, sp, dig;
    logic [15:0] acc_upd;
    logic [19:0] acc_x10;
    logic        emit;
    logic        has_res;
    logic        need_div;
    logic [1:0]  ekind, ecode;
    logic [7:0]  samp;
    logic [7:0]  er, eg, eb;
    logic        last;
    logic [16:0] rem_sh;
    logic [15:0] divisor;
    logic        hdr_ph;

    assign c = in_beat.data_byte;
    assign gray = (fmt_reg == pnm_pkg::FMT_P2) || (fmt_reg == pnm_pkg::FMT_P5);
    assign sp = pnm_pkg::is_space(c);
    assign dig = (c >= pnm_pkg::CH_0) && (c <= pnm_pkg::CH_9);
    assign divisor = (maxs_reg == 16'd0) ? 16'd1 : maxs_reg;
    assign rem_sh = {rem_reg, quo_reg[23]};
    assign last = ({1'b0, col_reg} + 13'd1 >= {1'b0, width_reg})
               && ({1'b0, rowc_reg} + 13'd1 >= {1'b0, height_reg});
    assign hdr_ph = (phase_reg == pnm_pkg::PH_WIDTH) || (phase_reg == pnm_pkg::PH_HEIGHT)
                 || (phase_reg == pnm_pkg::PH_MAXVAL);

    assign m_beat  = res_reg;
    assign m_valid = valid_reg;
    // busy_result, div_done, need_div
    assign stat = {valid_reg && !m_ready, cnt_reg == 5'd0, need_div};

    // byte handling, divider and result formation
    always_comb begin
        pnm_pkg::phase_t ph;
        ph = phase_reg;
        phase_next = phase_reg; fmt_next = fmt_reg; width_next = width_reg;
        height_next = height_reg; maxs_next = maxs_reg; acc_next = acc_reg;
        tok_next = tok_reg; com_next = com_reg; dd_next = dd_reg;
        chan_next = chan_reg; hred_next = hred_reg; hgrn_next = hgrn_reg;
        col_next = col_reg; rowc_next = rowc_reg; res_next = res_reg;
        quo_next = quo_reg; rem_next = rem_reg; cnt_next = cnt_reg;
        closed = 1'b0; emit = 1'b0; ekind = pnm_pkg::KIND_PIXEL; ecode = pnm_pkg::ERR_NONE;
        samp = c; acc_upd = acc_reg; acc_x10 = '0; er = 8'd0; eg = 8'd0; eb = 8'd0;
        need_div = 1'b0; has_res = 1'b0;
        valid_next = valid_reg;
        if (valid_reg && m_ready) valid_next = 1'b0;

        if (cmd.load) begin
            if (in_beat.start_of_file) begin
                ph = pnm_pkg::PH_MAGIC; fmt_next = pnm_pkg::FMT_P2;
                width_next = '0; height_next = '0; maxs_next = '0;
                tok_next = 1'b0; com_next = 1'b0; dd_next = 1'b0; chan_next = '0;
                hred_next = '0; hgrn_next = '0; col_next = '0; rowc_next = '0;
                acc_next = '0;
            end
            // token feed (header when hdr phase)
            if ((hdr_ph || ph == pnm_pkg::PH_PIXELS) && ph != pnm_pkg::PH_MAGIC) begin
                if (hdr_ph && com_reg) begin
                    if (c == pnm_pkg::CH_LF || c == pnm_pkg::CH_CR) com_next = 1'b0;
                end else if (sp) begin
                    if (tok_reg) begin
                        tok_next = 1'b0; closed = 1'b1;
                    end
                end else begin
                    acc_upd = acc_reg;
                    if (!tok_reg) begin
                        acc_upd = '0;
                    end
                    if (!tok_reg && hdr_ph && c == pnm_pkg::CH_HASH) begin
                        com_next = 1'b1;
                    end else begin
                        tok_next = 1'b1;
                        if (!tok_reg || !dd_reg) begin
                            if (dig) begin
                                acc_x10 = {4'd0, acc_upd} * 20'd10
                                        + {12'd0, c - pnm_pkg::CH_0};
                                acc_next = (acc_x10 > 20'd65535) ? 16'hFFFF
                                         : acc_x10[15:0];
                                dd_next = 1'b0;
                            end else begin
                                acc_next = acc_upd; dd_next = 1'b1;
                            end
                        end
                    end
                end
            end
            unique case (ph)
                pnm_pkg::PH_MAGIC: begin
                    if (c != pnm_pkg::CH_P) begin
                        emit = 1'b1; ekind = pnm_pkg::KIND_ERROR; ecode = pnm_pkg::ERR_MAGIC;
                    end else phase_next = pnm_pkg::PH_FORMAT;
                end
                pnm_pkg::PH_FORMAT: begin
                    phase_next = pnm_pkg::PH_WIDTH; tok_next = 1'b0; com_next = 1'b0;
                    if (c == pnm_pkg::CH_2) fmt_next = pnm_pkg::FMT_P2;
                    else if (c == pnm_pkg::CH_3) fmt_next = pnm_pkg::FMT_P3;
                    else if (c == pnm_pkg::CH_5) fmt_next = pnm_pkg::FMT_P5;
                    else if (c == pnm_pkg::CH_6) fmt_next = pnm_pkg::FMT_P6;
                    else begin
                        emit = 1'b1; ekind = pnm_pkg::KIND_ERROR; ecode = pnm_pkg::ERR_MAGIC;
                    end
                end
                pnm_pkg::PH_WIDTH, pnm_pkg::PH_HEIGHT: begin
                    phase_next = ph;
                    if (closed) begin
                        if (acc_reg == 16'd0 || acc_reg >= 16'(pnm_pkg::MAX_DIM)) begin
                            emit = 1'b1; ekind = pnm_pkg::KIND_ERROR;
                            ecode = pnm_pkg::ERR_DIM;
                        end else if (ph == pnm_pkg::PH_WIDTH) begin
                            width_next = acc_reg[11:0]; phase_next = pnm_pkg::PH_HEIGHT;
                        end else begin
                            height_next = acc_reg[11:0]; phase_next = pnm_pkg::PH_MAXVAL;
                        end
                    end
                end
                pnm_pkg::PH_MAXVAL: begin
                    if (closed) begin
                        if (acc_reg == 16'd0) begin
                            emit = 1'b1; ekind = pnm_pkg::KIND_ERROR;
                            ecode = pnm_pkg::ERR_MAXVAL;
                        end else begin
                            maxs_next = acc_reg; phase_next = pnm_pkg::PH_PIXELS;
                            tok_next = 1'b0; chan_next = '0; col_next = '0; rowc_next = '0;
                            emit = 1'b1; ekind = pnm_pkg::KIND_HEADER;
                        end
                    end
                end
                pnm_pkg::PH_PIXELS: begin
                    if (fmt_reg[1]) begin
                        emit = 1'b1;
                    end else if (closed) begin
                        need_div = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // divider start and steps
        if (cmd.div_start) begin
            quo_next = 24'({8'd0, acc_reg} * 24'd255);
            rem_next = '0; cnt_next = 5'(pnm_pkg::DIV_STEPS);
        end else if (cmd.div_step && cnt_reg != 5'd0) begin
            cnt_next = cnt_reg - 5'd1;
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next = 16'(rem_sh - {1'b0, divisor}); quo_next = {quo_reg[22:0], 1'b1};
            end else begin
                rem_next = rem_sh[15:0]; quo_next = {quo_reg[22:0], 1'b0};
            end
        end
        if (cmd.send) begin
            emit = 1'b1;
            samp = (quo_reg > 24'd255) ? 8'hFF : quo_reg[7:0];
        end

        // pixel assembly and result register
        if (emit) begin
            has_res = 1'b1;
            res_next = '0;
            res_next.kind = ekind;
            if (ekind == pnm_pkg::KIND_ERROR) begin
                res_next.error_code = ecode; phase_next = pnm_pkg::PH_ERROR;
            end else if (ekind == pnm_pkg::KIND_HEADER) begin
                res_next.is_gray = gray; res_next.width_out = width_reg;
                res_next.height_out = height_reg; res_next.maxval_out = acc_reg;
            end else if (!gray && chan_reg == 2'd0) begin
                hred_next = samp; chan_next = 2'd1; has_res = 1'b0;
            end else if (!gray && chan_reg == 2'd1) begin
                hgrn_next = samp; chan_next = 2'd2; has_res = 1'b0;
            end else begin
                chan_next = 2'd0;
                er = gray ? samp : hred_reg; eg = gray ? samp : hgrn_reg; eb = samp;
                res_next.red = er; res_next.green = eg; res_next.blue = eb;
                res_next.column = col_reg; res_next.row = rowc_reg;
                res_next.last_pixel = last; res_next.is_gray = gray;
                if ({1'b0, col_reg} + 13'd1 >= {1'b0, width_reg}) begin
                    col_next = '0; rowc_next = rowc_reg + 12'd1;
                end else col_next = col_reg + 12'd1;
                if (last) phase_next = pnm_pkg::PH_DONE;
            end
            if (has_res) valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pnm_pkg::PH_MAGIC; fmt_reg <= '0; width_reg <= '0;
            height_reg <= '0; maxs_reg <= '0; acc_reg <= '0; tok_reg <= 1'b0;
            com_reg <= 1'b0; dd_reg <= 1'b0; chan_reg <= '0; hred_reg <= '0;
            hgrn_reg <= '0; col_reg <= '0; rowc_reg <= '0; valid_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            phase_reg <= phase_next; fmt_reg <= fmt_next; width_reg <= width_next;
            height_reg <= height_next; maxs_reg <= maxs_next; acc_reg <= acc_next;
            tok_reg <= tok_next; com_reg <= com_next; dd_reg <= dd_next;
            chan_reg <= chan_next; hred_reg <= hred_next; hgrn_reg <= hgrn_next;
            col_reg <= col_next; rowc_reg <= rowc_next; valid_reg <= valid_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next; quo_reg <= quo_next; rem_reg <= rem_next;
    end
endmodule

// File: rtl/pnm_ctrl.sv
// sequencer: byte acceptance, ascii sample division and result hand-off
module pnm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pnm_pkg::status_t  stat,
    output pnm_pkg::cmd_t     cmd
);
    pnm_pkg::ctrl_state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pnm_pkg::C_IDLE: begin
                if (s_valid && s_ready && stat.need_div) state_next = pnm_pkg::C_DIV;
            end
            pnm_pkg::C_DIV: begin
                if (stat.div_done) state_next = pnm_pkg::C_SEND;
            end
            pnm_pkg::C_SEND: begin
                if (!stat.busy_result) state_next = pnm_pkg::C_IDLE;
            end
            default: state_next = pnm_pkg::C_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        s_ready = (state_reg == pnm_pkg::C_IDLE) && !stat.busy_result;
        unique case (state_reg)
            pnm_pkg::C_IDLE: begin
                cmd.load = s_valid && s_ready;
                cmd.div_start = cmd.load;
            end
            pnm_pkg::C_DIV:  cmd.div_step = 1'b1;
            pnm_pkg::C_SEND: cmd.send = !stat.busy_result;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= pnm_pkg::C_IDLE;
        else state_reg <= state_next;
    end
endmodule

// File: rtl/pnm_image_stream_decoder_core.sv
// top level of the pnm image stream decoder
// Takes a PGM/PPM file one byte per beat and returns header, error and pixel
// results. Header bytes and raw P5/P6 samples are taken one per cycle as long
// as each result is taken in the cycle it is offered; a result that waits
// blocks new bytes until it is taken. A byte that closes an ASCII P2/P3 sample
// starts a restoring divider, one quotient bit per cycle: after the 24 divide
// steps in C_DIV the sequencer sees the end, loads the result in C_SEND once the
// result register is free, and returns to C_IDLE; only then is the next byte taken.
module pnm_image_stream_decoder_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pnm_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pnm_pkg::out_beat_t  m_data
);
    pnm_pkg::cmd_t    cmd;
    pnm_pkg::status_t stat;

    pnm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .cmd(cmd)
    );

    pnm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_beat(s_data), .cmd(cmd), .stat(stat),
        .m_beat(m_data), .m_valid(m_valid), .m_ready(m_ready)
    );
endmodule

// File: bench/pnm_stream_checker.sv
// stream checker: predicts decoder results from accepted input beats and compares them
`timescale 1ns / 100ps
module pnm_stream_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  pnm_pkg::in_beat_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  pnm_pkg::out_beat_t m_data,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);
    typedef enum logic [2:0] {
        ST_MAGIC, ST_FORMAT, ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_PIXELS, ST_DONE, ST_ERROR
    } parse_st_t;

    parse_st_t   st;
    logic [1:0]  fmt;
    logic [11:0] img_w, img_h, col_cnt, row_cnt;
    logic [15:0] maxv, num_acc, red_hold, green_hold;
    logic        in_tok, in_cmt, digits_over;
    logic [1:0]  chan;
    pnm_pkg::out_beat_t expected_q[$];

    function automatic logic ws(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic pnm_pkg::out_beat_t blank();
        pnm_pkg::out_beat_t r;
        r = '0;
        return r;
    endfunction

    // tokenizer; returns 1 when a token just closed
    function automatic logic token_closed(input logic [7:0] c, input logic hdr);
        int v;
        if (hdr && in_cmt) begin
            if (c == pnm_pkg::CH_LF || c == pnm_pkg::CH_CR) in_cmt = 1'b0;
            return 1'b0;
        end
        if (ws(c)) begin
            if (in_tok) begin
                in_tok = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (!in_tok) begin
            if (hdr && c == pnm_pkg::CH_HASH) begin
                in_cmt = 1'b1;
                return 1'b0;
            end
            in_tok = 1'b1;
            digits_over = 1'b0;
            num_acc = '0;
        end
        if (!digits_over) begin
            if (c >= pnm_pkg::CH_0 && c <= pnm_pkg::CH_9) begin
                v = int'(num_acc) * 10 + int'(c - pnm_pkg::CH_0);
                num_acc = (v > 65535) ? 16'hFFFF : 16'(v);
            end else begin
                digits_over = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void clear_state();
        st = ST_MAGIC; fmt = pnm_pkg::FMT_P2; img_w = '0; img_h = '0; maxv = '0;
        num_acc = '0; in_tok = 0; in_cmt = 0; digits_over = 0; chan = '0; red_hold = '0;
        green_hold = '0; col_cnt = '0; row_cnt = '0;
    endfunction

    function automatic void push_error(input logic [1:0] code);
        pnm_pkg::out_beat_t r;
        r = blank();
        r.kind = pnm_pkg::KIND_ERROR;
        r.error_code = code;
        st = ST_ERROR;
        expected_q.push_back(r);
    endfunction

    function automatic void push_pixel(input logic [7:0] r8, g8, b8);
        pnm_pkg::out_beat_t r;
        logic lst;
        lst = (int'(col_cnt) + 1 >= int'(img_w)) && (int'(row_cnt) + 1 >= int'(img_h));
        r = blank();
        r.kind = pnm_pkg::KIND_PIXEL;
        r.red = r8; r.green = g8; r.blue = b8;
        r.column = col_cnt; r.row = row_cnt;
        r.last_pixel = lst;
        r.is_gray = (fmt == pnm_pkg::FMT_P2 || fmt == pnm_pkg::FMT_P5);
        expected_q.push_back(r);
        col_cnt++;
        if (col_cnt >= img_w) begin
            col_cnt = '0;
            row_cnt++;
        end
        if (lst) st = ST_DONE;
    endfunction

    // advance the decoder prediction by one accepted byte
    function automatic void predict_byte(input pnm_pkg::in_beat_t b);
        logic [7:0] c;
        longint     scaled;
        pnm_pkg::out_beat_t r;
        c = b.data_byte;
        if (b.start_of_file) clear_state();
        case (st)
            ST_MAGIC: begin
                if (c != pnm_pkg::CH_P) push_error(pnm_pkg::ERR_MAGIC);
                else st = ST_FORMAT;
            end
            ST_FORMAT: begin
                if (c == pnm_pkg::CH_2) fmt = pnm_pkg::FMT_P2;
                else if (c == pnm_pkg::CH_3) fmt = pnm_pkg::FMT_P3;
                else if (c == pnm_pkg::CH_5) fmt = pnm_pkg::FMT_P5;
                else if (c == pnm_pkg::CH_6) fmt = pnm_pkg::FMT_P6;
                else begin
                    push_error(pnm_pkg::ERR_MAGIC);
                    return;
                end
                in_tok = 0; in_cmt = 0; st = ST_WIDTH;
            end
            ST_WIDTH, ST_HEIGHT: begin
                if (token_closed(c, 1'b1)) begin
                    if (num_acc == 0 || num_acc >= pnm_pkg::MAX_DIM)
                        push_error(pnm_pkg::ERR_DIM);
                    else if (st == ST_WIDTH) begin
                        img_w = num_acc[11:0]; st = ST_HEIGHT;
                    end else begin
                        img_h = num_acc[11:0]; st = ST_MAXVAL;
                    end
                end
            end
            ST_MAXVAL: begin
                if (token_closed(c, 1'b1)) begin
                    if (num_acc == 0) push_error(pnm_pkg::ERR_MAXVAL);
                    else begin
                        maxv = num_acc;
                        st = ST_PIXELS; in_tok = 0; chan = '0; col_cnt = '0; row_cnt = '0;
                        r = blank();
                        r.kind = pnm_pkg::KIND_HEADER;
                        r.is_gray = (fmt == pnm_pkg::FMT_P2 || fmt == pnm_pkg::FMT_P5);
                        r.width_out = img_w; r.height_out = img_h; r.maxval_out = maxv;
                        expected_q.push_back(r);
                    end
                end
            end
            ST_PIXELS: begin
                if (fmt == pnm_pkg::FMT_P5 || fmt == pnm_pkg::FMT_P6) scaled = c;
                else begin
                    if (!token_closed(c, 1'b0)) return;
                    scaled = (longint'(num_acc) * 255) / (maxv == 0 ? 1 : longint'(maxv));
                    if (scaled > 255) scaled = 255;
                end
                if (fmt == pnm_pkg::FMT_P3 || fmt == pnm_pkg::FMT_P6) begin
                    if (chan == 0) begin
                        red_hold = 16'(scaled); chan = 1;
                    end else if (chan == 1) begin
                        green_hold = 16'(scaled); chan = 2;
                    end else begin
                        chan = 0;
                        push_pixel(red_hold[7:0], green_hold[7:0], 8'(scaled));
                    end
                end else begin
                    push_pixel(8'(scaled), 8'(scaled), 8'(scaled));
                end
            end
            default: ;
        endcase
    endfunction

    // watch both channels; outputs are checked before the input of the same edge is predicted
    always @(posedge aclk) begin
        pnm_pkg::out_beat_t want;
        if (!aresetn) begin
            clear_state();
            expected_q.delete();
            fail_count <= 0;
            result_count <= 0;
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (m_data !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) predict_byte(s_data);
            pending <= expected_q.size();
        end
    end
endmodule

// File: bench/tb_top.sv
// top of the pnm decoder testbench: byte stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_top;
    logic      aclk = 0;
    logic      aresetn = 0;
    logic      s_valid = 0;
    logic      s_ready;
    pnm_pkg::in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    pnm_pkg::out_beat_t m_data;
    int        fail_count, pending, result_count;
    int        cycles = 0;
    int        sent = 0;
    bit        calm = 0;
    byte unsigned file_bytes[$];

    localparam int CYCLE_LIMIT = 900000;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    pnm_image_stream_decoder_core dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    pnm_stream_checker chk (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    // result side stalls at random except in calm stretches
    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    end

    // run timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // send one byte, holding valid until accepted
    task automatic send_byte(input byte unsigned b, input bit sof);
        while (!calm && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.data_byte <= b;
        s_data.start_of_file <= sof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_file(input bit finish_idle);
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
        if (finish_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
    endtask

    function automatic string pick_ws();
        case ($urandom_range(5))
            0: return "\n";
            1: return "\t";
            2: return "\r";
            3: return "  ";
            default: return " ";
        endcase
    endfunction

    // build an image of random format and content; ascii samples may exceed maxval or carry junk
    task automatic build_image(input int fmt_sel, input int w, input int h, input int mv);
        int n;
        int smp;
        file_bytes.delete();
        add_str(fmt_sel == 0 ? "P2" : fmt_sel == 1 ? "P3" : fmt_sel == 2 ? "P5" : "P6");
        if ($urandom_range(3) == 0) add_str("\n# note x\n");
        else add_str(pick_ws());
        add_str($sformatf("%0d", w)); add_str(pick_ws());
        if ($urandom_range(4) == 0) add_str("#c\r");
        add_str($sformatf("%0d", h)); add_str(pick_ws());
        add_str($sformatf("%0d", mv));
        n = w * h * ((fmt_sel == 1 || fmt_sel == 3) ? 3 : 1);
        if (fmt_sel >= 2) begin
            add_str(" ");
            for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
        end else begin
            add_str(pick_ws());
            for (int i = 0; i < n; i++) begin
                smp = ($urandom_range(7) == 0) ? $urandom_range(70000) : $urandom_range(mv);
                add_str($sformatf("%0d", smp));
                if ($urandom_range(9) == 0) add_str("-x#");
                add_str(pick_ws());
            end
        end
        if ($urandom_range(2) == 0) add_str("tail");
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int f;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: bad magic, bad format digit, dimension and maxval errors
        file_bytes = '{8'h51, 8'h50}; send_file(0);
        add_str(""); file_bytes = '{8'h50, 8'h34, 8'h20}; send_file(0);
        file_bytes.delete(); add_str("P2 0 "); send_file(0);
        file_bytes.delete(); add_str("P5 4096 1 "); send_file(0);
        file_bytes.delete(); add_str("P6#z\n4095 -1 "); send_file(0);
        file_bytes.delete(); add_str("P3 1 1 0 "); send_file(0);
        // directed: tiny P5 and P2 images with extremes, saturating maxval
        file_bytes.delete(); add_str("P5 2 1 99999 "); file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF); send_file(0);
        file_bytes.delete(); add_str("P2 1 1 1\n1 "); send_file(0);
        wait_drained();

        // random images; small sizes mostly, one widest-row header cut short by a restart
        f = 0;
        while (sent < 500) begin
            calm = (f >= 6 && f < 10);
            build_image($urandom_range(3), $urandom_range(1, 4), $urandom_range(1, 3),
                        $urandom_range(3) == 0 ? 65535 : $urandom_range(1, 300));
            if (f == 12) begin
                file_bytes.delete();
                add_str("P5 4095 1 255 ");
                for (int i = 0; i < 24; i++) file_bytes.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(7) == 0) begin
                // noise: corrupt random bytes after the magic and format digit
                for (int i = 2; i < file_bytes.size(); i++)
                    if ($urandom_range(9) == 0) file_bytes[i] = 8'($urandom_range(255));
            end
            send_file(f % 5 == 0);
            if (f == 8) wait_drained();
            f++;
        end
        calm = 0;
        wait_drained();

        $display("covered %0d input bytes across all formats, errors and comments; %0d results",
                 sent, result_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
